FILE: rtl/rwcs_pkg.sv
package rwcs_pkg;

    localparam int SCREEN_HEIGHT = 512;
    localparam int HALF_H        = SCREEN_HEIGHT / 2;
    localparam int ROW_W         = 9;
    localparam int LH_NUM        = SCREEN_HEIGHT * 65536;
    localparam int LH_W          = 26;
    localparam int HALF_W        = LH_W - 1;

    localparam int DIV_NUM_W  = 28;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_NUM_W / DIV_STEP;

    localparam int TEX_LAT = 4;
    localparam int TW_W    = 11;
    localparam int TX_W    = 10;
    localparam int FRAC_W  = 16;

endpackage

FILE: rtl/rwcs_div.sv
module rwcs_div
    import rwcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_NUM_W-1:0] quo
);

    logic [DIV_DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [DIV_DEN_W-1:0] den_reg [DIV_STAGES];
    logic [DIV_NUM_W-1:0] num_reg [DIV_STAGES];
    logic [DIV_NUM_W-1:0] quo_reg [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            logic [DIV_DEN_W-1:0] rem_in;
            logic [DIV_DEN_W-1:0] den_in;
            logic [DIV_NUM_W-1:0] num_in;
            logic [DIV_NUM_W-1:0] quo_in;
            logic [DIV_DEN_W-1:0] rem_next;
            logic [DIV_NUM_W-1:0] num_next;
            logic [DIV_NUM_W-1:0] quo_next;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign den_in = den;
                assign num_in = num;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign den_in = den_reg[s-1];
                assign num_in = num_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            // restoring division, DIV_STEP (2) quotient bits per stage
            always_comb
            begin
                logic [DIV_DEN_W:0] trial;
                rem_next = rem_in;
                num_next = num_in;
                quo_next = quo_in;
                trial    = '0;
                for (int b = 0; b < DIV_STEP; b++)
                begin
                    trial    = {rem_next, num_next[DIV_NUM_W-1]};
                    num_next = {num_next[DIV_NUM_W-2:0], 1'b0};
                    if (trial >= {1'b0, den_in})
                    begin
                        trial    = trial - {1'b0, den_in};
                        quo_next = {quo_next[DIV_NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next = {quo_next[DIV_NUM_W-2:0], 1'b0};
                    end
                    rem_next = trial[DIV_DEN_W-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_in;
                    num_reg[s] <= num_next;
                    quo_reg[s] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

FILE: rtl/rwcs_tex.sv
module rwcs_tex
    import rwcs_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [31:0]       wall_dist,
    input  logic [31:0]       dir,
    input  logic [FRAC_W-1:0] cam_frac,
    input  logic [TW_W-1:0]   tex_width,
    input  logic              mirror,
    output logic [TX_W-1:0]   tex_col
);

    logic [FRAC_W-1:0]      prod_reg;
    logic [FRAC_W-1:0]      cam_reg;
    logic [TW_W-1:0]        tw1_reg;
    logic [TW_W-1:0]        tw2_reg;
    logic [TW_W-1:0]        tw3_reg;
    logic                   mir1_reg;
    logic                   mir2_reg;
    logic                   mir3_reg;
    logic [FRAC_W-1:0]      frac_reg;
    logic [TW_W+FRAC_W-1:0] scaled_reg;
    logic [TW_W-1:0]        tx_reg;

    logic [31:0]            prod_next;
    logic [TW_W-1:0]        tx_next;

    // low product bits are the same for signed and unsigned operands
    assign prod_next = wall_dist * dir;

    always_comb
    begin
        if (mir3_reg)
            tx_next = tw3_reg - scaled_reg[TW_W+FRAC_W-1:FRAC_W] - TW_W'(1);
        else
            tx_next = scaled_reg[TW_W+FRAC_W-1:FRAC_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next[31:16];
            cam_reg    <= cam_frac;
            tw1_reg    <= tex_width;
            mir1_reg   <= mirror;
            frac_reg   <= prod_reg + cam_reg;
            tw2_reg    <= tw1_reg;
            mir2_reg   <= mir1_reg;
            scaled_reg <= frac_reg * tw2_reg;
            tw3_reg    <= tw2_reg;
            mir3_reg   <= mir2_reg;
            tx_reg     <= tx_next;
        end
    end

    assign tex_col = tx_reg[TX_W-1:0];

endmodule

FILE: rtl/raycast_wall_column_setup_unit.sv
// wall column setup for a grid raycaster, one screen column per item
// input channel: in_valid / in_stall carry one ray hit per item (side and
// delta distances, ray direction, camera position, column, hit side)
// output channel: out_valid / out_stall carry the wall slice rows, face,
// texture column, texture step, starting texture row and wall distance
// config channel: cfg_valid / cfg_ready with cfg_index (0 texture width,
// 1 texture height) and cfg_data; always ready, write only while idle
// latency: 33 register stages; the chain is two pipelined restoring
// dividers (2 quotient bits a stage, 14 stages each) plus the surrounding
// multiply and clamp stages
// throughput: one item per cycle while the receiver does not stall, no bubbles
// when the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is lost or repeated
// reset clears all valid bits and sets both texture sizes to 64
module raycast_wall_column_setup_unit
    import rwcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] side_dist_x,
    input  logic [31:0] side_dist_y,
    input  logic [31:0] delta_dist_x,
    input  logic [31:0] delta_dist_y,
    input  logic [31:0] ray_dir_x,
    input  logic [31:0] ray_dir_y,
    input  logic [31:0] cam_pos_x,
    input  logic [31:0] cam_pos_y,
    input  logic [9:0]  column,
    input  logic        hit_side,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  start_row,
    output logic [8:0]  end_row,
    output logic [9:0]  column_out,
    output logic [1:0]  wall_face,
    output logic        side_out,
    output logic [9:0]  tex_column,
    output logic [31:0] tex_step,
    output logic [31:0] tex_row_start,
    output logic [31:0] wall_distance
);

    localparam int NSTG   = 2 * DIV_STAGES + 5;
    localparam int TX_DLY = DIV_STAGES - TEX_LAT;

    localparam logic [0:0] REG_TEX_WIDTH  = 1'b0;
    localparam logic [0:0] REG_TEX_HEIGHT = 1'b1;

    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_WEST  = 2'd2;
    localparam logic [1:0] FACE_EAST  = 2'd3;

    typedef struct packed {
        logic [9:0]  column;
        logic        side;
        logic [1:0]  face;
        logic [31:0] wall_dist;
    } side_t;

    typedef struct packed {
        logic [ROW_W-1:0]  start;
        logic [ROW_W-1:0]  stop;
        logic [HALF_W-1:0] k;
        logic              lh_zero;
        logic [TX_W-1:0]   tx;
    } geo_t;

    logic             en;
    logic [NSTG:1]    vld_reg;
    logic [TW_W-1:0]  tw_reg;
    logic [TW_W-1:0]  th_reg;

    // entry stage
    logic [32:0]       diff;
    logic [31:0]       d_next;
    side_t             s1_next;
    logic              mir_next;
    side_t             s1_reg;
    logic [31:0]       den1_reg;
    logic [31:0]       dir1_reg;
    logic [FRAC_W-1:0] cam1_reg;
    logic              mir1_reg;

    side_t             side_line_reg [DIV_STAGES];
    logic [TX_W-1:0]   tx_line_reg [TX_DLY];
    logic [TX_W-1:0]   tx_col;

    logic [DIV_NUM_W-1:0] quo_a;
    logic [DIV_NUM_W-1:0] quo_b;
    logic [LH_W-1:0]      lh;
    logic [HALF_W-1:0]    lh_half;
    geo_t                 g16_next;
    geo_t                 g16_reg;
    side_t                s16_reg;
    logic [LH_W-1:0]      lh16_reg;
    logic [TW_W-1:0]      th16_reg;

    geo_t              geo_line_reg [DIV_STAGES];
    side_t             side2_line_reg [DIV_STAGES];

    geo_t              g31_reg;
    side_t             s31_reg;
    logic [31:0]       step31_reg;
    geo_t              g32_reg;
    side_t             s32_reg;
    logic [31:0]       step32_reg;
    logic [HALF_W+31:0] kprod32_reg;
    logic [31:0]       trs_next;

    assign en        = !(vld_reg[NSTG] && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= TW_W'(64);
            th_reg <= TW_W'(64);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEX_WIDTH:  tw_reg <= cfg_data;
                REG_TEX_HEIGHT: th_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-1:1], in_valid};
    end

    // distance on the hit axis, saturated
    always_comb
    begin
        if (hit_side)
            diff = {side_dist_y[31], side_dist_y} - {delta_dist_y[31], delta_dist_y};
        else
            diff = {side_dist_x[31], side_dist_x} - {delta_dist_x[31], delta_dist_x};
        if (diff[32] != diff[31])
            d_next = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            d_next = diff[31:0];
        s1_next.column    = column;
        s1_next.side      = hit_side;
        s1_next.wall_dist = d_next;
        if (hit_side)
        begin
            s1_next.face = ray_dir_y[31] ? FACE_NORTH : FACE_SOUTH;
            mir_next     = ray_dir_y[31];
        end
        else
        begin
            s1_next.face = ray_dir_x[31] ? FACE_WEST : FACE_EAST;
            mir_next     = !ray_dir_x[31] && (ray_dir_x != 32'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1_next;
            den1_reg <= (!d_next[31] && d_next != 32'd0) ? d_next : 32'd1;
            dir1_reg <= hit_side ? ray_dir_x : ray_dir_y;
            cam1_reg <= hit_side ? cam_pos_x[FRAC_W-1:0] : cam_pos_y[FRAC_W-1:0];
            mir1_reg <= mir_next;
        end
    end

    rwcs_div u_div_height
    (
        .clk (clk),
        .en  (en),
        .num (DIV_NUM_W'(LH_NUM)),
        .den (den1_reg),
        .quo (quo_a)
    );

    rwcs_tex u_tex
    (
        .clk       (clk),
        .en        (en),
        .wall_dist (s1_reg.wall_dist),
        .dir       (dir1_reg),
        .cam_frac  (cam1_reg),
        .tex_width (tw_reg),
        .mirror    (mir1_reg),
        .tex_col   (tx_col)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_line_reg[0] <= s1_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                side_line_reg[i] <= side_line_reg[i-1];
            tx_line_reg[0] <= tx_col;
            for (int i = 1; i < TX_DLY; i++)
                tx_line_reg[i] <= tx_line_reg[i-1];
        end
    end

    // row clamps from the line height
    assign lh      = quo_a[LH_W-1:0];
    assign lh_half = lh[LH_W-1:1];

    always_comb
    begin
        g16_next.lh_zero = (lh == '0);
        g16_next.tx      = tx_line_reg[TX_DLY-1];
        if (lh_half >= HALF_W'(HALF_H))
        begin
            g16_next.start = '0;
            g16_next.stop  = ROW_W'(SCREEN_HEIGHT - 1);
            g16_next.k     = lh_half - HALF_W'(HALF_H);
        end
        else
        begin
            g16_next.start = ROW_W'(HALF_H) - lh_half[ROW_W-1:0];
            g16_next.stop  = ROW_W'(HALF_H) + lh_half[ROW_W-1:0];
            g16_next.k     = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g16_reg  <= g16_next;
            s16_reg  <= side_line_reg[DIV_STAGES-1];
            lh16_reg <= lh;
            th16_reg <= th_reg;
        end
    end

    rwcs_div u_div_step
    (
        .clk (clk),
        .en  (en),
        .num (DIV_NUM_W'({th16_reg, 16'h0000})),
        .den (DIV_DEN_W'(lh16_reg)),
        .quo (quo_b)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_line_reg[0]   <= g16_reg;
            side2_line_reg[0] <= s16_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                geo_line_reg[i]   <= geo_line_reg[i-1];
                side2_line_reg[i] <= side2_line_reg[i-1];
            end
        end
    end

    // texture row at the first drawn row, saturated
    assign trs_next = (kprod32_reg > (HALF_W+32)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                  : kprod32_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g31_reg     <= geo_line_reg[DIV_STAGES-1];
            s31_reg     <= side2_line_reg[DIV_STAGES-1];
            step31_reg  <= geo_line_reg[DIV_STAGES-1].lh_zero ? 32'hFFFF_FFFF
                                                              : 32'(quo_b);
            g32_reg     <= g31_reg;
            s32_reg     <= s31_reg;
            step32_reg  <= step31_reg;
            kprod32_reg <= g31_reg.k * step31_reg;

            start_row     <= g32_reg.start;
            end_row       <= g32_reg.stop;
            column_out    <= s32_reg.column;
            wall_face     <= s32_reg.face;
            side_out      <= s32_reg.side;
            tex_column    <= g32_reg.tx;
            tex_step      <= step32_reg;
            tex_row_start <= trs_next;
            wall_distance <= s32_reg.wall_dist;
        end
    end

    assign out_valid = vld_reg[NSTG];

endmodule

FILE: verif/tb_raycast_wall_column_setup_unit.sv
module tb_raycast_wall_column_setup_unit;
    import rwcs_pkg::*;

    localparam int CFG_TEX_WIDTH  = 0;
    localparam int CFG_TEX_HEIGHT = 1;
    localparam int N_RANDOM       = 1230;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic [31:0] sdx;
        logic [31:0] sdy;
        logic [31:0] ddx;
        logic [31:0] ddy;
        logic [31:0] rdx;
        logic [31:0] rdy;
        logic [31:0] cpx;
        logic [31:0] cpy;
        logic [9:0]  col;
        logic        side;
    } ray_hit_t;

    typedef struct packed {
        logic [8:0]  start_row;
        logic [8:0]  end_row;
        logic [9:0]  column_out;
        logic [1:0]  wall_face;
        logic        side_out;
        logic [9:0]  tex_column;
        logic [31:0] tex_step;
        logic [31:0] tex_row_start;
        logic [31:0] wall_distance;
    } wall_slice_t;

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic wall_slice_t predict_slice(ray_hit_t r, longint tw, longint th);
        wall_slice_t s;
        longint h, d, lh, st, en, k, trs, dir, cam, prod;
        longint unsigned frac, tx, step;
        logic mirror;
        h = SCREEN_HEIGHT;
        if (r.side)
            d = clamp_s32(longint'($signed(r.sdy)) - longint'($signed(r.ddy)));
        else
            d = clamp_s32(longint'($signed(r.sdx)) - longint'($signed(r.ddx)));
        lh = (d <= 0) ? h * 65536 : (h * 65536) / d;
        st = h / 2 - lh / 2;
        if (st < 0)
            st = 0;
        en = lh / 2 + h / 2;
        if (en >= h)
            en = h - 1;
        if (r.side)
        begin
            s.wall_face = ($signed(r.rdy) < 0) ? 2'd0 : 2'd1;
            mirror = $signed(r.rdy) < 0;
            dir = $signed(r.rdx);
            cam = $signed(r.cpx);
        end
        else
        begin
            s.wall_face = ($signed(r.rdx) < 0) ? 2'd2 : 2'd3;
            mirror = $signed(r.rdx) > 0;
            dir = $signed(r.rdy);
            cam = $signed(r.cpy);
        end
        prod = d * dir;
        frac = ((unsigned'(prod) >> 16) + unsigned'(cam)) & 64'hFFFF;
        tx = (frac * tw) >> 16;
        if (mirror)
            tx = tw - tx - 1;
        step = (lh == 0) ? 64'hFFFFFFFF : (unsigned'(th) << 16) / lh;
        k = st - h / 2 + lh / 2;
        trs = (k == 0) ? 0 : clamp_s32(k * longint'(step));
        s.start_row = st[8:0];
        s.end_row = en[8:0];
        s.column_out = r.col;
        s.side_out = r.side;
        s.tex_column = tx[9:0];
        s.tex_step = step[31:0];
        s.tex_row_start = trs[31:0];
        s.wall_distance = d[31:0];
        return s;
    endfunction

    class slice_scoreboard;
        wall_slice_t pending[$];
        int mismatches;
        int checked;
        longint tw;
        longint th;

        function void note_ray(ray_hit_t r);
            pending.push_back(predict_slice(r, tw, th));
        endfunction

        function void check_slice(wall_slice_t got);
            wall_slice_t exp;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected slice %h", got);
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("slice mismatch expected %h", exp);
                    $display("               actual   %h", got);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    ray_hit_t ray;
    logic cfg_valid;
    logic cfg_ready;
    logic [0:0] cfg_index;
    logic [10:0] cfg_data;
    logic out_valid;
    logic out_stall;
    wall_slice_t slice;

    slice_scoreboard sb;
    bit quiet_tail;
    bit long_holdoff;
    int idle_cycles;
    int sent;

    raycast_wall_column_setup_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .side_dist_x(ray.sdx), .side_dist_y(ray.sdy),
        .delta_dist_x(ray.ddx), .delta_dist_y(ray.ddy),
        .ray_dir_x(ray.rdx), .ray_dir_y(ray.rdy),
        .cam_pos_x(ray.cpx), .cam_pos_y(ray.cpy),
        .column(ray.col), .hit_side(ray.side),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .start_row(slice.start_row), .end_row(slice.end_row),
        .column_out(slice.column_out), .wall_face(slice.wall_face),
        .side_out(slice.side_out), .tex_column(slice.tex_column),
        .tex_step(slice.tex_step), .tex_row_start(slice.tex_row_start),
        .wall_distance(slice.wall_distance)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 32'h0010_0000);
            3: return -$urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic ray_hit_t random_ray();
        ray_hit_t r;
        logic [31:0] hit_dist;
        r.sdx = pick_word();
        r.sdy = pick_word();
        r.ddx = pick_word();
        r.ddy = pick_word();
        r.rdx = pick_word();
        r.rdy = pick_word();
        r.cpx = $urandom;
        r.cpy = $urandom;
        r.col = 10'($urandom);
        r.side = 1'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            // plausible hit: small positive distance on the hit axis
            hit_dist = $urandom_range(1, 32'h0040_0000);
            r.ddx = $urandom_range(0, 32'h0010_0000);
            r.ddy = $urandom_range(0, 32'h0010_0000);
            r.sdx = r.ddx + hit_dist;
            r.sdy = r.ddy + hit_dist;
            r.rdx = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            r.rdy = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        end
        return r;
    endfunction

    task automatic send_ray(ray_hit_t r);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ray <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_ray(r);
        sent++;
    endtask

    task automatic write_reg(int idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= 1'(idx);
        cfg_data <= 11'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TEX_WIDTH)
            sb.tw = val;
        else
            sb.th = val;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic directed_ray(logic [31:0] sd, logic [31:0] dd, logic [31:0] rx,
                                logic [31:0] ry, logic sd_side);
        ray_hit_t r;
        r = random_ray();
        r.side = sd_side;
        if (sd_side)
        begin
            r.sdy = sd;
            r.ddy = dd;
        end
        else
        begin
            r.sdx = sd;
            r.ddx = dd;
        end
        r.rdx = rx;
        r.rdy = ry;
        send_ray(r);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_slice(slice);
    end

    // receiver stalls
    initial
    begin
        int burst;
        out_stall <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_holdoff)
            begin
                out_stall <= 1'b1;
                repeat (80) @(posedge clk);
                out_stall <= 1'b0;
                long_holdoff = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 4);
                out_stall <= 1'b1;
                repeat (burst - 1) @(posedge clk);
                @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int widths[5];
        int heights[5];
        sb = new();
        sb.tw = 64;
        sb.th = 64;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        ray = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        widths = '{64, 1, 1024, 0, 2047};
        heights = '{64, 1024, 1, 0, 2047};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_ray(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0, 1'b0);
        directed_ray(32'h0, 32'h0, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
        directed_ray(32'h0001_0000, 32'h0002_0000, 32'h0, 32'hFFFF_0000, 1'b1);
        directed_ray(32'h0000_0001, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
        directed_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        directed_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        directed_ray(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
        directed_ray(32'h0200_0001, 32'h0, 32'h1234_5678, 32'h0, 1'b1);
        directed_ray(32'h0000_8000, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        directed_ray(32'h0000_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
        begin
            ray_hit_t r;
            r = '1;
            send_ray(r);
            r = '0;
            send_ray(r);
        end

        for (phase = 0; phase < 5; phase++)
        begin
            drain();
            write_reg(CFG_TEX_WIDTH, widths[phase]);
            write_reg(CFG_TEX_HEIGHT, heights[phase]);
            directed_ray(32'h0001_0000, 32'h0, 32'h0000_4000, 32'h0000_C000, 1'b0);
            directed_ray(32'h7FFF_FFFF, 32'h0, 32'h0000_4000, 32'hFFFF_C000, 1'b1);
            if (phase == 1)
                long_holdoff = 1'b1;
            if (phase == 4)
                quiet_tail = 1'b1;
            repeat (N_RANDOM / 5)
                send_ray(random_ray());
        end

        drain();
        $display("sent %0d ray hits over 5 texture size settings, %0d slices checked",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
        begin
            $display("%0d mismatches, %0d slices outstanding",
                     sb.mismatches, sb.pending.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
